[hdl/swcc_pkg.sv]
// Shared types and constants for the sliding-window congestion controller.
// No dependencies; every other file in the block imports this package.
package swcc_pkg;

  // Opcodes of an input word.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_SYNC  = 2'd1,
    OP_ACK   = 2'd2,
    OP_TIMER = 2'd3
  } swcc_op_t;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_STARTED  = 4'd0,
    ST_HANDSHK  = 4'd1,
    ST_ACK_OK   = 4'd2,
    ST_DONE     = 4'd3,
    ST_DUP      = 4'd4,
    ST_DUP_HALF = 4'd5,
    ST_TMO_QTR  = 4'd6,
    ST_NO_TMO   = 4'd7,
    ST_IGNORED  = 4'd8
  } swcc_status_t;

  // Transfer phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SYNC = 2'd1,
    PH_SEND = 2'd2,
    PH_DONE = 2'd3
  } swcc_phase_t;

  // Controller states.
  typedef enum logic [2:0] {
    C_IDLE,
    C_STEP_A,
    C_STEP_B,
    C_STEP_C,
    C_DIV,
    C_ADJ,
    C_SETTLE,
    C_FIN
  } swcc_state_t;

  // Configuration register indexes.
  localparam logic CFG_PAYLOAD = 1'b0;
  localparam logic CFG_MAXWIN  = 1'b1;

  localparam int CWND_W = 24;
  localparam int RTT_W  = 27;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step_a;
    logic step_b;
    logic step_c;
    logic adj;
    logic settle;
    logic out_load;
  } swcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic need_settle;
    logic div_done;
  } swcc_sts_t;

endpackage

[hdl/swcc_mod_unit.sv]
// Bit-serial remainder unit: dividend modulo a 16-bit divisor, one bit a cycle.
// Depends on swcc_pkg for the window width.
module swcc_mod_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [swcc_pkg::CWND_W-1:0] dividend,
  input  logic [15:0]                 divisor,
  output logic                        done,
  output logic [15:0]                 remainder
);
  import swcc_pkg::*;

  localparam int CNT_W = $clog2(CWND_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CWND_W-1:0] sh_r, sh_nxt;
  logic [15:0]       part_r, part_nxt;
  logic [16:0]       trial;

  // One restoring step: bring in the next dividend bit and subtract if it fits.
  always_comb begin
    trial    = {part_r, sh_r[CWND_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    part_nxt = part_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = dividend;
      part_nxt = '0;
    end else if (busy_r) begin
      part_nxt = (trial >= {1'b0, divisor}) ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      sh_nxt   = sh_r << 1;
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(CWND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r   <= sh_nxt;
    part_r <= part_nxt;
  end

  assign done      = done_r;
  assign remainder = part_r;

endmodule

[hdl/swcc_datapath.sv]
// Datapath: configuration, window state, RTT estimator, output word register.
// Depends on swcc_pkg and swcc_mod_unit.
module swcc_datapath #(
  parameter int SW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swcc_pkg::swcc_cmd_t  cmd,
  output swcc_pkg::swcc_sts_t  sts,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [23:0]          cfg_wdata,
  input  logic [1:0]           in_opcode,
  input  logic [31:0]          in_ack_number,
  input  logic [23:0]          in_elapsed_q8,
  input  logic [31:0]          in_transfer_bytes,
  output logic [3:0]           out_status,
  output logic [31:0]          out_window_first,
  output logic [31:0]          out_window_last,
  output logic [23:0]          out_window_bytes,
  output logic [31:0]          out_remaining_bytes,
  output logic [31:0]          out_timeout_interval_q8
);
  import swcc_pkg::*;

  // Configuration.
  logic [15:0]       pay_r;
  logic [23:0]       maxw_r;
  // Transfer state.
  swcc_phase_t       phase_r;
  logic [SW-1:0]     first_r, last_r;
  logic [CWND_W-1:0] cwnd_r;
  logic [31:0]       rem_r;
  logic [RTT_W-1:0]  rtt_r, dev_r;
  logic [31:0]       rto_r;
  logic [1:0]        dup_r;
  // Current word and work registers.
  swcc_op_t          op_r;
  logic [SW-1:0]     ack_r, d_r;
  logic [23:0]       smp_r;
  logic [31:0]       tot_r;
  logic              hit_r;
  logic              grow_r;
  logic [CWND_W-1:0] c_r;
  swcc_status_t      status_r;
  // Output word.
  logic [3:0]        o_status_r;
  logic [31:0]       o_first_r, o_last_r, o_rem_r, o_rto_r;
  logic [23:0]       o_cwnd_r;

  logic [15:0]       pay;
  logic [SW-1:0]     d_a;
  logic [29:0]       rtt_sum;
  logic [RTT_W-1:0]  diff;
  logic [28:0]       dev_sum;
  logic              need_div, need_settle;
  logic [CWND_W-1:0] div_arg;
  logic              div_done;
  logic [15:0]       div_rem;
  logic [24:0]       adj_c;
  logic [31:0]       lo;
  logic [31:0]       set_c;

  assign pay = (pay_r == 16'd0) ? 16'd1 : pay_r;

  // Step A arithmetic: ack offset and smoothed RTT.
  assign d_a     = ack_r - first_r;
  assign rtt_sum = ({3'd0, rtt_r} << 3) - {3'd0, rtt_r} + 30'(smp_r);

  // Step B arithmetic: deviation.
  always_comb begin
    diff    = (RTT_W'(smp_r) > rtt_r) ? RTT_W'(smp_r) - rtt_r : rtt_r - RTT_W'(smp_r);
    dev_sum = 29'(dev_r) + (29'(dev_r) << 1) + 29'(diff);
  end

  // Step C decision: is a resize due, does it need a remainder, and which
  // window value it starts from.
  always_comb begin
    need_div    = 1'b0;
    need_settle = 1'b0;
    div_arg     = cwnd_r;
    case (op_r)
      OP_START: begin
        need_settle = (tot_r != 32'd0);
        div_arg     = CWND_W'(pay);
      end
      OP_ACK: begin
        if (phase_r == PH_SEND) begin
          if (hit_r) begin
            if (rem_r != 32'd0) begin
              if (cwnd_r < maxw_r) need_div = 1'b1;
              else begin
                need_settle = 1'b1;
                div_arg     = maxw_r;
              end
            end
          end else if (dup_r == 2'd2) begin
            need_div = 1'b1;
            div_arg  = cwnd_r >> 1;
          end
        end
      end
      OP_TIMER: begin
        if (phase_r == PH_SEND && 32'(smp_r) > rto_r) begin
          need_div = 1'b1;
          div_arg  = cwnd_r >> 2;
        end
      end
      default: ;
    endcase
  end

  swcc_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.step_c & need_div),
    .dividend (div_arg),
    .divisor  (pay),
    .done     (div_done),
    .remainder(div_rem)
  );

  assign sts.need_div    = need_div;
  assign sts.need_settle = need_settle;
  assign sts.div_done    = div_done;

  // Round a shrunk window up, or grow to the next payload multiple.
  always_comb begin
    if (grow_r) begin
      adj_c = 25'(c_r) + 25'(pay) - 25'(div_rem);
      if (adj_c > 25'(maxw_r)) adj_c = 25'(maxw_r);
    end else begin
      adj_c = 25'(c_r) + ((div_rem != 16'd0) ? 25'(pay - div_rem) : 25'd0);
    end
  end

  // Settle: cap by bytes left, floor at min(payload, bytes left).
  always_comb begin
    lo    = (32'(pay) < rem_r) ? 32'(pay) : rem_r;
    set_c = 32'(c_r);
    if (set_c > rem_r) set_c = rem_r;
    if (set_c < lo) set_c = lo;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pay_r  <= 16'd1024;
      maxw_r <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAYLOAD: pay_r  <= cfg_wdata[15:0];
        CFG_MAXWIN:  maxw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= swcc_op_t'(in_opcode);
      ack_r <= SW'(in_ack_number);
      smp_r <= in_elapsed_q8;
      tot_r <= in_transfer_bytes;
    end
  end

  // Transfer state updates, one command at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      first_r  <= '0;
      last_r   <= '0;
      cwnd_r   <= '0;
      rem_r    <= '0;
      rtt_r    <= '0;
      dev_r    <= '0;
      rto_r    <= '0;
      dup_r    <= '0;
      hit_r    <= 1'b0;
      grow_r   <= 1'b0;
      status_r <= ST_IGNORED;
    end else begin
      if (cmd.step_a) begin
        d_r      <= d_a;
        hit_r    <= (d_a != '0) && (65'(d_a) <= 65'(cwnd_r));
        status_r <= ST_IGNORED;
        if (op_r == OP_ACK && phase_r == PH_SEND && d_a != '0 && 65'(d_a) <= 65'(cwnd_r)) begin
          rtt_r <= RTT_W'(rtt_sum >> 3);
        end
      end
      if (cmd.step_b && op_r == OP_ACK && phase_r == PH_SEND && hit_r) begin
        dev_r   <= RTT_W'(dev_sum >> 2);
        rem_r   <= (65'(d_r) > 65'(rem_r)) ? 32'd0 : rem_r - 32'(d_r);
        first_r <= ack_r;
      end
      if (cmd.step_c) begin
        c_r    <= div_arg;
        grow_r <= (op_r == OP_ACK) && hit_r;
        case (op_r)
          OP_START: begin
            rem_r   <= tot_r;
            first_r <= '0;
            dup_r   <= '0;
            if (tot_r == 32'd0) begin
              phase_r  <= PH_DONE;
              cwnd_r   <= '0;
              last_r   <= '1;
              status_r <= ST_DONE;
            end else begin
              phase_r  <= PH_SYNC;
              status_r <= ST_STARTED;
            end
          end
          OP_SYNC: begin
            if (phase_r == PH_SYNC) begin
              rtt_r    <= RTT_W'(smp_r) * RTT_W'(6);
              dev_r    <= RTT_W'(smp_r) * RTT_W'(3);
              rto_r    <= 32'(smp_r) * 32'd18;
              phase_r  <= PH_SEND;
              status_r <= ST_HANDSHK;
            end
          end
          OP_ACK: begin
            if (phase_r == PH_SEND) begin
              if (hit_r) begin
                rto_r <= 32'(rtt_r) + (32'(dev_r) << 2);
                if (rem_r == 32'd0) begin
                  phase_r  <= PH_DONE;
                  cwnd_r   <= '0;
                  last_r   <= first_r - SW'(1);
                  dup_r    <= '0;
                  status_r <= ST_DONE;
                end else begin
                  status_r <= ST_ACK_OK;
                end
              end else if (dup_r == 2'd2) begin
                status_r <= ST_DUP_HALF;
              end else begin
                dup_r    <= dup_r + 2'd1;
                status_r <= ST_DUP;
              end
            end
          end
          OP_TIMER: begin
            if (phase_r == PH_SEND) begin
              if (32'(smp_r) > rto_r) begin
                rto_r    <= rto_r[31] ? 32'hFFFF_FFFF : rto_r << 1;
                status_r <= ST_TMO_QTR;
              end else begin
                status_r <= ST_NO_TMO;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.adj) begin
        c_r <= CWND_W'(adj_c);
      end
      if (cmd.settle) begin
        cwnd_r <= CWND_W'(set_c);
        last_r <= first_r + SW'(set_c) - SW'(1);
        dup_r  <= '0;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status_r <= status_r;
      o_first_r  <= 32'(first_r);
      o_last_r   <= 32'(last_r);
      o_cwnd_r   <= cwnd_r;
      o_rem_r    <= rem_r;
      o_rto_r    <= rto_r;
    end
  end

  assign out_status              = o_status_r;
  assign out_window_first        = o_first_r;
  assign out_window_last         = o_last_r;
  assign out_window_bytes        = o_cwnd_r;
  assign out_remaining_bytes     = o_rem_r;
  assign out_timeout_interval_q8 = o_rto_r;

endmodule

[hdl/swcc_ctrl.sv]
// Controller: sequences the datapath steps and runs both handshakes.
// Depends on swcc_pkg.
module swcc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output swcc_pkg::swcc_cmd_t cmd,
  input  swcc_pkg::swcc_sts_t sts
);
  import swcc_pkg::*;

  swcc_state_t state_r, state_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic        out_free;

  assign out_free = !ovalid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE:   if (in_valid) state_nxt = C_STEP_A;
      C_STEP_A: state_nxt = C_STEP_B;
      C_STEP_B: state_nxt = C_STEP_C;
      C_STEP_C: begin
        if (sts.need_div) state_nxt = C_DIV;
        else if (sts.need_settle) state_nxt = C_SETTLE;
        else state_nxt = C_FIN;
      end
      C_DIV:    if (sts.div_done) state_nxt = C_ADJ;
      C_ADJ:    state_nxt = C_SETTLE;
      C_SETTLE: state_nxt = C_FIN;
      C_FIN:    if (out_free) state_nxt = C_IDLE;
      default:  state_nxt = C_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd          = '0;
    in_stall     = (state_r != C_IDLE);
    cmd.load     = (state_r == C_IDLE) && in_valid;
    cmd.step_a   = (state_r == C_STEP_A);
    cmd.step_b   = (state_r == C_STEP_B);
    cmd.step_c   = (state_r == C_STEP_C);
    cmd.adj      = (state_r == C_ADJ);
    cmd.settle   = (state_r == C_SETTLE);
    cmd.out_load = (state_r == C_FIN) && out_free;
    ovalid_nxt   = cmd.out_load ? 1'b1 : (ovalid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= C_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

endmodule

[hdl/sliding_window_congestion_control_unit.sv]
// Channel   Direction  Handshake             Contents
// in_       input      in_valid / in_stall   opcode, ack number, elapsed, length
// out_      output     out_valid / out_stall status, window, bytes left, timeout
// cfg_      input      cfg_we                payload size, maximum window
// A word is accepted when idle, then runs steps A, B, C and the output load; a
// resize adds a settle step, after a bit-serial remainder by the payload size
// and an adjust step if needed. The result sits in an output register, so the
// next word is taken once it is loaded. Reset (rst_n low, synchronous) idles
// the block with an empty output; a stalled output holds its word.
module sliding_window_congestion_control_unit #(
  parameter int SEQUENCE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_ack_number,
  input  logic [23:0] in_elapsed_q8,
  input  logic [31:0] in_transfer_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [31:0] out_window_first,
  output logic [31:0] out_window_last,
  output logic [23:0] out_window_bytes,
  output logic [31:0] out_remaining_bytes,
  output logic [31:0] out_timeout_interval_q8
);
  import swcc_pkg::*;

  swcc_cmd_t cmd;
  swcc_sts_t sts;

  swcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  swcc_datapath #(.SW(SEQUENCE_WIDTH)) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_opcode              (in_opcode),
    .in_ack_number          (in_ack_number),
    .in_elapsed_q8          (in_elapsed_q8),
    .in_transfer_bytes      (in_transfer_bytes),
    .out_status             (out_status),
    .out_window_first       (out_window_first),
    .out_window_last        (out_window_last),
    .out_window_bytes       (out_window_bytes),
    .out_remaining_bytes    (out_remaining_bytes),
    .out_timeout_interval_q8(out_timeout_interval_q8)
  );

endmodule

[hdl/swcc_checker.sv]
// Port-level checks for the congestion controller, bound to its top level.
// Depends on swcc_pkg for the status codes.
module swcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_status,
  input logic [31:0] out_window_first,
  input logic [23:0] out_window_bytes
);
  import swcc_pkg::*;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

  // One word at a time: the block is busy right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // A finished transfer shows an empty window.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DONE |-> out_window_bytes == 24'd0)
    else $error("done with open window");

  // A started transfer begins at sequence zero with an open window.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_STARTED |-> out_window_first == 32'd0 &&
    out_window_bytes != 24'd0)
    else $error("bad start window");

endmodule

bind sliding_window_congestion_control_unit swcc_checker u_swcc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_window_first(out_window_first),
  .out_window_bytes(out_window_bytes)
);
